### hw/rtl/lcns_pkg.sv
`timescale 1ns / 1ps
package lcns_pkg;

    localparam int MAX_PICTURES = 512;
    localparam int VEC_LEN      = 256;
    localparam int TOP_SLOTS    = 16;

    localparam int PIC_W    = $clog2(MAX_PICTURES);
    localparam int CNT_W    = $clog2(MAX_PICTURES + 1);
    localparam int ELEM_W   = $clog2(VEC_LEN);
    localparam int ECNT_W   = $clog2(VEC_LEN + 1);
    localparam int ADDR_W   = $clog2(MAX_PICTURES * VEC_LEN);
    localparam int TOP_W    = $clog2(TOP_SLOTS + 1);
    localparam int TERM_W   = 34;
    localparam int ACC_W    = TERM_W + ELEM_W;
    localparam int SQ_W     = ACC_W + (ACC_W % 2);
    localparam int SQ_STEPS = SQ_W / 2;
    localparam int STEP_W   = $clog2(SQ_STEPS + 1);
    localparam int MBIT_W   = $clog2(CNT_W);

    localparam logic [31:0] DIST_INF = 32'hFFFF_FFFF;
    localparam logic [31:0] DIST_SAT = 32'hFFFF_FFFE;

    localparam logic [2:0] CFG_MODE    = 3'd0;
    localparam logic [2:0] CFG_TOP     = 3'd1;
    localparam logic [2:0] CFG_WINDOW  = 3'd2;
    localparam logic [2:0] CFG_REFRESH = 3'd3;
    localparam logic [2:0] CFG_GAP     = 3'd4;

    typedef struct packed {
        logic signed [15:0] feature_value;
        logic               last_element;
    } lcns_in_t;

    typedef struct packed {
        logic [8:0]  picture_index;
        logic        match_found;
        logic [8:0]  match_index;
        logic [31:0] match_distance;
        logic        store_full;
    } lcns_out_t;

endpackage

### hw/rtl/loop_closure_neighbor_search.sv
`timescale 1ns / 1ps
// Loop-closure neighbor search. Feature elements are taken one per cycle
// while the block waits for input and no result is pending. After the last
// element of a picture the block is busy: it zero-fills the rest of the
// stored vector, runs the refresh check, scans each earlier picture in the
// search range, streams each candidate picture through the one subtract /
// multiply-accumulate unit (one feature store read per cycle), takes the
// bit-serial square root in Euclidean mode, and inserts into the top list;
// then it rebuilds the candidate mask over the earlier pictures and presents
// the result. The input is held off while a result waits to be taken.
module loop_closure_neighbor_search (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  lcns_pkg::lcns_in_t  s_data,
    output logic                m_valid,
    input  logic                m_ready,
    output lcns_pkg::lcns_out_t m_data,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic [2:0]          cfg_index,
    input  logic [15:0]         cfg_data
);
    import lcns_pkg::*;

    localparam logic [3:0] ST_LOAD  = 4'd0;
    localparam logic [3:0] ST_ZFILL = 4'd1;
    localparam logic [3:0] ST_MOD   = 4'd2;
    localparam logic [3:0] ST_SRD   = 4'd3;
    localparam logic [3:0] ST_SCHK  = 4'd4;
    localparam logic [3:0] ST_DIST  = 4'd5;
    localparam logic [3:0] ST_SQRT  = 4'd6;
    localparam logic [3:0] ST_INS   = 4'd7;
    localparam logic [3:0] ST_MASK  = 4'd8;
    localparam logic [3:0] ST_DONE  = 4'd9;

    logic [3:0]        state_reg, state_next;
    logic [CNT_W-1:0]  pc_reg, pc_next;
    logic [ECNT_W-1:0] ec_reg, ec_next;
    logic [CNT_W-1:0]  j_reg, j_next;
    logic [ECNT_W-1:0] k_reg, k_next;
    logic              v1_reg, v1_next, v2_reg, v2_next;
    logic [TERM_W-1:0] term_reg, term_next;
    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [SQ_W-1:0]   sx_reg, sx_next, sr_reg, sr_next, sb_reg, sb_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic [31:0]       dist_reg, dist_next;
    logic [CNT_W-1:0]  found_reg, found_next;
    logic [TOP_W-1:0]  kept_reg, kept_next;
    logic [PIC_W-1:0]  tid_reg [TOP_SLOTS];
    logic [PIC_W-1:0]  tid_next [TOP_SLOTS];
    logic [31:0]       tdist_reg [TOP_SLOTS];
    logic [31:0]       tdist_next [TOP_SLOTS];
    logic [CNT_W-1:0]  mlen_reg, mlen_next;
    logic [11:0]       rem_reg, rem_next;
    logic [MBIT_W-1:0] mbit_reg, mbit_next;
    lcns_out_t         out_reg, out_next;
    logic              mv_reg, mv_next;

    logic              mode_reg;
    logic [4:0]        topc_reg;
    logic [7:0]        win_reg;
    logic [11:0]       per_reg;
    logic [9:0]        gap_reg;

    logic              st_we, cur_we, msk_we, bd_we;
    logic [ADDR_W-1:0] st_waddr, st_raddr;
    logic [15:0]       st_wdata, st_rdata;
    logic [ELEM_W-1:0] cur_waddr, cur_raddr;
    logic [15:0]       cur_rdata;
    logic              msk_wdata, msk_rdata;
    logic [31:0]       bd_wdata, bd_rdata;

    logic [TOP_W-1:0]  lim;
    logic              full;
    logic              out_free;

    assign cfg_ready = 1'b1;
    assign full      = pc_reg >= CNT_W'(MAX_PICTURES);
    assign out_free  = !mv_reg || m_ready;
    assign s_ready   = (state_reg == ST_LOAD) && out_free;
    assign m_valid   = mv_reg;
    assign m_data    = out_reg;

    always_comb begin
        if (topc_reg == 5'd0) begin
            lim = TOP_W'(1);
        end else if (TOP_W'(topc_reg) > TOP_W'(TOP_SLOTS)) begin
            lim = TOP_W'(TOP_SLOTS);
        end else begin
            lim = TOP_W'(topc_reg);
        end
    end

    assign cur_raddr = k_reg[ELEM_W-1:0];
    assign st_raddr  = ADDR_W'(j_reg[PIC_W-1:0]) * ADDR_W'(VEC_LEN)
                     + ADDR_W'(k_reg[ELEM_W-1:0]);

    lcns_ram #(.WIDTH(16), .DEPTH(MAX_PICTURES * VEC_LEN)) u_store (
        .aclk(aclk), .we(st_we), .waddr(st_waddr), .wdata(st_wdata),
        .raddr(st_raddr), .rdata(st_rdata)
    );
    lcns_ram #(.WIDTH(16), .DEPTH(VEC_LEN)) u_cur (
        .aclk(aclk), .we(cur_we), .waddr(cur_waddr), .wdata(st_wdata),
        .raddr(cur_raddr), .rdata(cur_rdata)
    );
    lcns_ram #(.WIDTH(1), .DEPTH(MAX_PICTURES)) u_mask (
        .aclk(aclk), .we(msk_we), .waddr(j_reg[PIC_W-1:0]), .wdata(msk_wdata),
        .raddr(j_reg[PIC_W-1:0]), .rdata(msk_rdata)
    );
    lcns_ram #(.WIDTH(32), .DEPTH(MAX_PICTURES)) u_best (
        .aclk(aclk), .we(bd_we), .waddr(pc_reg[PIC_W-1:0]), .wdata(bd_wdata),
        .raddr(tid_reg[0]), .rdata(bd_rdata)
    );

    always_comb begin
        logic               acc_s;
        logic [ECNT_W-1:0]  widx;
        logic signed [16:0] diff;
        logic [SQ_W-1:0]    trial;
        logic [12:0]        sh;
        logic [TOP_W-1:0]   pos;
        logic               near;
        logic [10:0]        lo_chk, hi_chk;
        logic [CNT_W:0]     fplus;

        state_next = state_reg;
        pc_next    = pc_reg;
        ec_next    = ec_reg;
        j_next     = j_reg;
        k_next     = k_reg;
        v1_next    = 1'b0;
        v2_next    = 1'b0;
        term_next  = term_reg;
        acc_next   = acc_reg;
        sx_next    = sx_reg;
        sr_next    = sr_reg;
        sb_next    = sb_reg;
        step_next  = step_reg;
        dist_next  = dist_reg;
        found_next = found_reg;
        kept_next  = kept_reg;
        tid_next   = tid_reg;
        tdist_next = tdist_reg;
        mlen_next  = mlen_reg;
        rem_next   = rem_reg;
        mbit_next  = mbit_reg;
        out_next   = out_reg;
        mv_next    = mv_reg && !m_ready;

        st_we     = 1'b0;
        cur_we    = 1'b0;
        msk_we    = 1'b0;
        bd_we     = 1'b0;
        widx      = ec_reg;
        st_wdata  = 16'd0;
        msk_wdata = 1'b0;
        bd_wdata  = (kept_reg != '0) ? tdist_reg[0] : DIST_INF;

        acc_s  = s_valid && s_ready;
        diff   = 17'(signed'(cur_rdata)) - 17'(signed'(st_rdata));
        trial  = sr_reg + sb_reg;
        sh     = {rem_reg, pc_reg[mbit_reg]};
        pos    = '0;
        near   = 1'b0;
        lo_chk = '0;
        hi_chk = '0;
        fplus  = {1'b0, found_reg} + (CNT_W+1)'(1);

        unique case (state_reg)
            ST_LOAD: begin
                if (acc_s) begin
                    if (!full && ec_reg < ECNT_W'(VEC_LEN)) begin
                        st_we    = 1'b1;
                        cur_we   = 1'b1;
                        st_wdata = s_data.feature_value;
                    end
                    if (ec_reg < ECNT_W'(VEC_LEN)) begin
                        ec_next = ec_reg + ECNT_W'(1);
                    end
                    if (s_data.last_element) begin
                        if (full) begin
                            ec_next  = '0;
                            out_next = '{picture_index: 9'd0, match_found: 1'b0,
                                         match_index: 9'd0, match_distance: DIST_INF,
                                         store_full: 1'b1};
                            mv_next  = 1'b1;
                        end else begin
                            k_next     = ec_next;
                            state_next = ST_ZFILL;
                        end
                    end
                end
            end
            ST_ZFILL: begin
                widx = k_reg;
                if (k_reg == ECNT_W'(VEC_LEN)) begin
                    ec_next    = '0;
                    rem_next   = '0;
                    mbit_next  = MBIT_W'(CNT_W - 1);
                    state_next = ST_MOD;
                end else begin
                    st_we  = 1'b1;
                    cur_we = 1'b1;
                    k_next = k_reg + ECNT_W'(1);
                end
            end
            ST_MOD: begin
                // n mod refresh_period, one bit of n per cycle
                if (sh >= {1'b0, per_reg}) begin
                    rem_next = 12'(sh - {1'b0, per_reg});
                end else begin
                    rem_next = sh[11:0];
                end
                mbit_next = mbit_reg - MBIT_W'(1);
                if (mbit_reg == '0) begin
                    j_next     = '0;
                    found_next = '0;
                    kept_next  = '0;
                    state_next = ST_SRD;
                end
            end
            ST_SRD: begin
                if (({1'b0, j_reg} + {1'b0, gap_reg}) >= {1'b0, pc_reg}) begin
                    j_next     = '0;
                    state_next = ST_MASK;
                end else begin
                    state_next = ST_SCHK;
                end
            end
            ST_SCHK: begin
                if (j_reg < mlen_reg && msk_rdata) begin
                    k_next     = '0;
                    acc_next   = '0;
                    state_next = ST_DIST;
                end else begin
                    j_next     = j_reg + CNT_W'(1);
                    state_next = ST_SRD;
                end
            end
            ST_DIST: begin
                if (k_reg < ECNT_W'(VEC_LEN)) begin
                    k_next  = k_reg + ECNT_W'(1);
                    v1_next = 1'b1;
                end
                if (v1_reg) begin
                    if (mode_reg) begin
                        term_next = TERM_W'(diff < 0 ? -diff : diff);
                    end else begin
                        term_next = TERM_W'(diff) * TERM_W'(diff);
                    end
                    v2_next = 1'b1;
                end
                if (v2_reg) begin
                    acc_next = acc_reg + ACC_W'(term_reg);
                end
                if (k_reg == ECNT_W'(VEC_LEN) && !v1_reg && !v2_reg) begin
                    if (mode_reg) begin
                        dist_next  = (acc_reg > ACC_W'(DIST_SAT)) ? DIST_SAT
                                                                  : acc_reg[31:0];
                        state_next = ST_INS;
                    end else begin
                        sx_next    = SQ_W'(acc_reg);
                        sr_next    = '0;
                        sb_next    = SQ_W'(1) << (SQ_W - 2);
                        step_next  = STEP_W'(SQ_STEPS);
                        state_next = ST_SQRT;
                    end
                end
            end
            ST_SQRT: begin
                if (step_reg == '0) begin
                    dist_next  = sr_reg[31:0];
                    state_next = ST_INS;
                end else begin
                    if (sx_reg >= trial) begin
                        sx_next = sx_reg - trial;
                        sr_next = (sr_reg >> 1) + sb_reg;
                    end else begin
                        sr_next = sr_reg >> 1;
                    end
                    sb_next   = sb_reg >> 2;
                    step_next = step_reg - STEP_W'(1);
                end
            end
            ST_INS: begin
                // list stays sorted; equal distances keep the earlier picture first
                for (int t = 0; t < TOP_SLOTS; t++) begin
                    if (TOP_W'(t) < kept_reg && tdist_reg[t] <= dist_reg) begin
                        pos = pos + TOP_W'(1);
                    end
                end
                found_next = found_reg + CNT_W'(1);
                if (pos < lim) begin
                    if (kept_reg < lim) begin
                        kept_next = kept_reg + TOP_W'(1);
                    end
                    for (int t = 0; t < TOP_SLOTS; t++) begin
                        if (TOP_W'(t) == pos) begin
                            tid_next[t]   = j_reg[PIC_W-1:0];
                            tdist_next[t] = dist_reg;
                        end else if (t > 0 && TOP_W'(t) > pos && TOP_W'(t) < kept_next) begin
                            tid_next[t]   = tid_reg[t-1];
                            tdist_next[t] = tdist_reg[t-1];
                        end
                    end
                end
                j_next     = j_reg + CNT_W'(1);
                state_next = ST_SRD;
            end
            ST_MASK: begin
                if (j_reg < pc_reg) begin
                    for (int t = 0; t < TOP_SLOTS; t++) begin
                        lo_chk = 11'(j_reg) + 11'(win_reg);
                        hi_chk = 11'(tid_reg[t]) + 11'(win_reg);
                        if (TOP_W'(t) < kept_reg && lo_chk >= 11'(tid_reg[t])
                            && 11'(j_reg) <= hi_chk) begin
                            near = 1'b1;
                        end
                    end
                    msk_we    = 1'b1;
                    msk_wdata = near || (fplus < (CNT_W+1)'(lim))
                             || (per_reg != '0 && rem_reg == '0);
                    j_next    = j_reg + CNT_W'(1);
                end else begin
                    mlen_next  = pc_reg;
                    bd_we      = 1'b1;
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (out_free) begin
                    out_next = '{picture_index: pc_reg[8:0],
                                 match_found: kept_reg != '0,
                                 match_index: (kept_reg != '0) ? 9'(tid_reg[0]) : 9'd0,
                                 match_distance: (kept_reg != '0) ? bd_rdata : DIST_INF,
                                 store_full: 1'b0};
                    mv_next    = 1'b1;
                    pc_next    = pc_reg + CNT_W'(1);
                    state_next = ST_LOAD;
                end
            end
            default: begin
                state_next = ST_LOAD;
            end
        endcase

        st_waddr  = ADDR_W'(pc_reg[PIC_W-1:0]) * ADDR_W'(VEC_LEN)
                  + ADDR_W'(widx[ELEM_W-1:0]);
        cur_waddr = widx[ELEM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_LOAD;
            pc_reg    <= '0;
            ec_reg    <= '0;
            mlen_reg  <= '0;
            mv_reg    <= 1'b0;
            v1_reg    <= 1'b0;
            v2_reg    <= 1'b0;
            mode_reg  <= 1'b0;
            topc_reg  <= 5'd10;
            win_reg   <= 8'd30;
            per_reg   <= 12'd300;
            gap_reg   <= 10'd80;
        end else begin
            state_reg <= state_next;
            pc_reg    <= pc_next;
            ec_reg    <= ec_next;
            mlen_reg  <= mlen_next;
            mv_reg    <= mv_next;
            v1_reg    <= v1_next;
            v2_reg    <= v2_next;
            if (cfg_valid) begin
                unique case (cfg_index)
                    CFG_MODE:    mode_reg <= cfg_data[0];
                    CFG_TOP:     topc_reg <= cfg_data[4:0];
                    CFG_WINDOW:  win_reg  <= cfg_data[7:0];
                    CFG_REFRESH: per_reg  <= cfg_data[11:0];
                    CFG_GAP:     gap_reg  <= cfg_data[9:0];
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge aclk) begin
        j_reg     <= j_next;
        k_reg     <= k_next;
        term_reg  <= term_next;
        acc_reg   <= acc_next;
        sx_reg    <= sx_next;
        sr_reg    <= sr_next;
        sb_reg    <= sb_next;
        step_reg  <= step_next;
        dist_reg  <= dist_next;
        found_reg <= found_next;
        kept_reg  <= kept_next;
        tid_reg   <= tid_next;
        tdist_reg <= tdist_next;
        rem_reg   <= rem_next;
        mbit_reg  <= mbit_next;
        out_reg   <= out_next;
    end
endmodule

### hw/rtl/lcns_ram.sv
`timescale 1ns / 1ps
module lcns_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
